// ----- design/bitsliced_clause_evaluator_unit_macros.svh -----
// Assertion macros for the bit-parallel clause evaluator.
// The macros sample on clk and are disabled while arst_n is low.
`ifndef BITSLICED_CLAUSE_EVALUATOR_UNIT_MACROS_SVH
`define BITSLICED_CLAUSE_EVALUATOR_UNIT_MACROS_SVH

// A condition that must hold at every clock edge.
`define BCE_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define BCE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define BCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bce_pkg.sv -----
// Shared types and constants of the bit-parallel clause evaluator.
// No dependencies; imported by the literal store, the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

	// Sizing of the block.
	localparam int LANES          = 64;
	localparam int MAX_LITERALS   = 2048;
	localparam int MAX_CLAUSE_LEN = 16;

	// Fixed field widths of the items.
	localparam int LIT_W  = 11;
	localparam int WORD_W = 64;

	// Derived widths. The store size is a power of two; the literal wraps onto it.
	localparam int ADDR_W = ($clog2(MAX_LITERALS) < LIT_W) ? $clog2(MAX_LITERALS) : LIT_W;
	localparam int ROW_W  = ADDR_W - 1;
	localparam int ROWS   = 2 ** ROW_W;
	localparam int LEN_W  = $clog2(MAX_CLAUSE_LEN + 1);
	localparam int IDX_W  = $clog2(MAX_CLAUSE_LEN);

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_CLAUSE = 2'd1,
		OP_START  = 2'd2,
		OP_QUERY  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_UNIT    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_FORMULA = 2'd2
	} kind_t;

	typedef enum logic {
		ST_RUN  = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [LIT_W-1:0]    literal;
		logic [WORD_W-1:0]   word;
		logic                last;
	} item_t;

	typedef struct packed {
		kind_t               kind;
		logic [LIT_W-1:0]    literal_res;
		logic [WORD_W-1:0]   lanes;
		logic                overflow;
		logic                last_res;
	} result_t;

endpackage

`default_nettype wire

// ----- design/bce_lit_store.sv -----
// Literal truth-word store: two synchronous memories, even and odd literals.
// A literal and its complement share one row, so one read yields both words.
// Depends on bce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bce_lit_store (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic                       rd_en,
	input  wire logic [bce_pkg::LIT_W-1:0]  literal,
	input  wire logic [bce_pkg::LANES-1:0]  wr_data,
	output logic      [bce_pkg::LANES-1:0]  pos_lanes,
	output logic      [bce_pkg::LANES-1:0]  neg_lanes
);
	import bce_pkg::*;

	logic [LANES-1:0] even_mem [ROWS];
	logic [LANES-1:0] odd_mem  [ROWS];
	logic [LANES-1:0] even_rd_q;
	logic [LANES-1:0] odd_rd_q;
	logic             odd_sel_q;
	logic [ROW_W-1:0] row;

	assign row = literal[ADDR_W-1:1];

	// Writes go to the half that holds the literal's polarity.
	always_ff @(posedge clk) begin
		if (wr_en && !literal[0]) begin
			even_mem[row] <= wr_data;
		end
		if (wr_en && literal[0]) begin
			odd_mem[row] <= wr_data;
		end
	end

	// Both halves of the row are read together; the data is registered and ready in the next cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			even_rd_q <= even_mem[row];
			odd_rd_q  <= odd_mem[row];
			odd_sel_q <= literal[0];
		end
	end

	// Steer the literal's own word and its complement's word.
	assign pos_lanes = odd_sel_q ? odd_rd_q  : even_rd_q;
	assign neg_lanes = odd_sel_q ? even_rd_q : odd_rd_q;

endmodule

`default_nettype wire

// ----- design/bitsliced_clause_evaluator_unit.sv -----
// Bit-parallel clause evaluator: top level with clause tracking and result sequencing.
// Depends on bce_pkg, bce_lit_store and bitsliced_clause_evaluator_unit_macros.svh.
//
// Usage. An item on "item" is taken at a rising edge where start is high and busy
// is low. Opcodes: write a literal's 64-lane truth word, stream one clause literal
// (last marks the end of the clause), start a new formula, or query the formula.
// Results appear on "result" with strobe high for exactly one cycle each; the
// receiver cannot hold them off, so every strobed cycle is one delivered result.
//
// Timing. Writes, start and non-final clause literals can follow back to back. A
// query's result passes through the stage 1 register and the output register before
// it is strobed. A final clause literal keeps busy high while the stage 1 register
// holds the store read of its two truth words, then while the unit scan walks the
// clause buffer entry by entry (up to 16 buffered literals), and for the
// clause-done result. Unit results are strobed only for literals with unit lanes.
// The rate is set by the single store read port pair and by the one-entry-per-cycle
// scan of the clause buffer.
//
// Reset. arst_n clears the clause masks, the formula mask (all lanes satisfied),
// the sequencer and the strobe. The literal store is not cleared; each literal
// word must be written before a clause reads it.
`timescale 1ns / 1ps
`default_nettype none
`include "bitsliced_clause_evaluator_unit_macros.svh"

module bitsliced_clause_evaluator_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bce_pkg::item_t   item,
	output logic                  strobe,
	output bce_pkg::result_t      result
);
	import bce_pkg::*;

	logic                 accept;
	logic [LANES-1:0]     pos_lanes;
	logic [LANES-1:0]     neg_lanes;

	// Stage 1: item waiting for its store read data.
	logic                 valid_s1;
	opcode_t              opcode_s1;
	logic [LIT_W-1:0]     literal_s1;
	logic                 last_s1;
	logic                 clause_s1;

	// Clause and formula state.
	logic [LANES-1:0]     none_q;
	logic [LANES-1:0]     amo_q;
	logic [LANES-1:0]     true_q;
	logic [LANES-1:0]     formula_q;
	logic [LEN_W-1:0]     len_q;
	logic                 over_q;
	logic [LIT_W-1:0]     lits_q [MAX_CLAUSE_LEN];
	logic [LANES-1:0]     free_q [MAX_CLAUSE_LEN];

	// Sequencer.
	state_t               state_q;
	state_t               state_d;
	logic [LEN_W-1:0]     idx_q;
	logic                 scan_end;
	logic                 clause_end;

	// Next mask values and the scan's current entry.
	logic [LANES-1:0]     none_d;
	logic [LANES-1:0]     amo_d;
	logic [LANES-1:0]     true_d;
	logic [LANES-1:0]     free_d;
	logic [LANES-1:0]     unit_mask;
	logic [LANES-1:0]     assign_lanes;

	// Output register.
	logic                 strobe_d;
	result_t              result_d;
	logic                 strobe_q;
	result_t              result_q;

	// Handshake. The block stalls while a clause end is being resolved.
	assign clause_s1 = valid_s1 && (opcode_s1 == OP_CLAUSE);
	assign busy      = (state_q == ST_EMIT) || (clause_s1 && last_s1);
	assign accept    = start && !busy;

	// Store write and paired read both happen at the accepting edge, so a write
	// is always visible to any later clause literal.
	bce_lit_store u_store (
		.clk       (clk),
		.wr_en     (accept && (item.opcode == OP_WRITE)),
		.rd_en     (accept && (item.opcode == OP_CLAUSE)),
		.literal   (item.literal),
		.wr_data   (item.word[LANES-1:0]),
		.pos_lanes (pos_lanes),
		.neg_lanes (neg_lanes)
	);

	// Stage 1 control register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1  <= item.opcode;
			literal_s1 <= item.literal;
			last_s1    <= item.last;
		end
	end

	// Per-lane literal counting: a lane is non-false unless the complement is true.
	assign amo_d  = (amo_q & neg_lanes) | none_q;
	assign none_d = none_q & neg_lanes;
	assign true_d = true_q | pos_lanes;
	assign free_d = ~(pos_lanes | neg_lanes);

	// Scan of the clause buffer.
	assign scan_end     = (idx_q == len_q);
	assign clause_end   = (state_q == ST_EMIT) && scan_end;
	assign unit_mask    = none_q ^ amo_q;
	assign assign_lanes = unit_mask & free_q[idx_q[IDX_W-1:0]];

	// Clause masks, length and formula mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			none_q    <= '1;
			amo_q     <= '1;
			true_q    <= '0;
			formula_q <= '1;
			len_q     <= '0;
			over_q    <= 1'b0;
		end else if (valid_s1 && (opcode_s1 == OP_START)) begin
			none_q    <= '1;
			amo_q     <= '1;
			true_q    <= '0;
			formula_q <= '1;
			len_q     <= '0;
			over_q    <= 1'b0;
		end else if (clause_end) begin
			none_q    <= '1;
			amo_q     <= '1;
			true_q    <= '0;
			formula_q <= formula_q & true_q;
			len_q     <= '0;
			over_q    <= 1'b0;
		end else if (clause_s1) begin
			none_q <= none_d;
			amo_q  <= amo_d;
			true_q <= true_d;
			if (len_q < LEN_W'(MAX_CLAUSE_LEN)) begin
				len_q <= len_q + LEN_W'(1);
			end else begin
				over_q <= 1'b1;
			end
		end
	end

	// Clause buffer: literals past the buffer depth still update the clause masks but are not kept.
	always_ff @(posedge clk) begin
		if (clause_s1 && (len_q < LEN_W'(MAX_CLAUSE_LEN))) begin
			lits_q[len_q[IDX_W-1:0]] <= literal_s1;
			free_q[len_q[IDX_W-1:0]] <= free_d;
		end
	end

	// Sequencer state and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT) begin
				idx_q <= idx_q + LEN_W'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (clause_s1 && last_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (scan_end) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// Result selection: query answers in RUN, unit and clause-done items in EMIT.
	always_comb begin
		strobe_d = 1'b0;
		result_d = '{kind: KIND_UNIT, literal_res: '0, lanes: '0,
			overflow: 1'b0, last_res: 1'b0};
		unique case (state_q)
			ST_RUN: begin
				if (valid_s1 && (opcode_s1 == OP_QUERY)) begin
					strobe_d          = 1'b1;
					result_d.kind     = KIND_FORMULA;
					result_d.lanes    = WORD_W'(formula_q);
					result_d.last_res = 1'b1;
				end
			end
			ST_EMIT: begin
				if (scan_end) begin
					strobe_d          = 1'b1;
					result_d.kind     = KIND_DONE;
					result_d.lanes    = WORD_W'(true_q);
					result_d.overflow = over_q;
					result_d.last_res = 1'b1;
				end else if (assign_lanes != '0) begin
					strobe_d             = 1'b1;
					result_d.kind        = KIND_UNIT;
					result_d.literal_res = lits_q[idx_q[IDX_W-1:0]];
					result_d.lanes       = WORD_W'(assign_lanes);
					result_d.overflow    = over_q;
				end
			end
			default: begin
				strobe_d = 1'b0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// Checks on the sequencer and the result stream.
	`BCE_ASSERT_NEXT(a_end_starts_scan, clause_s1 && last_s1, state_q == ST_EMIT, "clause end did not start the scan")
	`BCE_ASSERT_HOLDS(a_len_bound, len_q <= LEN_W'(MAX_CLAUSE_LEN), "clause length past buffer depth")
	`BCE_ASSERT_IMPLIES(a_unit_nonzero, strobe && (result.kind == KIND_UNIT), result.lanes != '0 && !result.last_res, "bad unit item")
	`BCE_ASSERT_IMPLIES(a_scan_in_range, state_q == ST_EMIT, idx_q <= len_q, "scan index past clause length")

endmodule

`default_nettype wire

// ----- dv/bce_clause_checker.sv -----
`timescale 1ns / 1ps
// Checker for the bit-parallel clause evaluator: watches the item and result channels,
// predicts results from its own copy of the literal store and clause masks, and compares.
// Depends on bce_pkg for the item, result, opcode and kind types.

module bce_clause_checker
	import bce_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    busy,
	input  wire item_t   item,
	input  wire logic    strobe,
	input  wire result_t result,
	output int           mismatches,
	output int           outstanding
);

	// Shadow copy of the literal store and of the clause under evaluation.
	logic [WORD_W-1:0] truth_words [MAX_LITERALS];
	logic [LIT_W-1:0]  clause_lits [MAX_CLAUSE_LEN];
	logic [WORD_W-1:0] clause_free [MAX_CLAUSE_LEN];
	logic [WORD_W-1:0] none_open;
	logic [WORD_W-1:0] one_open;
	logic [WORD_W-1:0] sat_lanes;
	logic [WORD_W-1:0] formula_mask;
	int                clause_len;
	bit                clause_overflowed;
	result_t           awaited_results [$];

	task automatic report_mismatch(string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic drop_clause();
		none_open = '1;
		one_open = '1;
		sat_lanes = '0;
		clause_len = 0;
		clause_overflowed = 1'b0;
	endtask

	task automatic push_result(kind_t kind, logic [LIT_W-1:0] lit, logic [WORD_W-1:0] lanes,
			bit ovf, bit closing);
		result_t r;
		r.kind = kind;
		r.literal_res = lit;
		r.lanes = lanes;
		r.overflow = ovf;
		r.last_res = closing;
		awaited_results = {awaited_results, r};
	endtask

	// Work out the results that one accepted item causes and update the shadow state.
	task automatic evaluate_item(item_t it);
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] neg;
		logic [WORD_W-1:0] unit_lanes;
		logic [WORD_W-1:0] hit;
		case (it.opcode)
			OP_WRITE: begin
				truth_words[int'(it.literal) % MAX_LITERALS] = it.word;
			end
			OP_START: begin
				formula_mask = '1;
				drop_clause();
			end
			OP_QUERY: begin
				push_result(KIND_FORMULA, '0, formula_mask, 1'b0, 1'b1);
			end
			default: begin
				pos = truth_words[int'(it.literal) % MAX_LITERALS];
				neg = truth_words[int'(it.literal ^ 11'd1) % MAX_LITERALS];
				one_open = (one_open & neg) | none_open;
				none_open &= neg;
				sat_lanes |= pos;
				// Literals past the buffer still count toward the masks but are not kept.
				if (clause_len < MAX_CLAUSE_LEN) begin
					clause_lits[clause_len] = it.literal;
					clause_free[clause_len] = ~(pos | neg);
					clause_len++;
				end else begin
					clause_overflowed = 1'b1;
				end
				if (it.last) begin
					unit_lanes = none_open ^ one_open;
					for (int i = 0; i < clause_len; i++) begin
						hit = unit_lanes & clause_free[i];
						if (hit != '0)
							push_result(KIND_UNIT, clause_lits[i], hit, clause_overflowed, 1'b0);
					end
					push_result(KIND_DONE, '0, sat_lanes, clause_overflowed, 1'b1);
					formula_mask &= sat_lanes;
					drop_clause();
				end
			end
		endcase
	endtask

	task automatic check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Compare one strobed result against the oldest waiting expectation.
	task automatic check_result(result_t got);
		result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing waiting: %p", got));
		end else begin
			want = awaited_results.pop_front();
			check_field("kind", 64'(got.kind), 64'(want.kind));
			check_field("literal_res", 64'(got.literal_res), 64'(want.literal_res));
			check_field("lanes", got.lanes, want.lanes);
			check_field("overflow", 64'(got.overflow), 64'(want.overflow));
			check_field("last_res", 64'(got.last_res), 64'(want.last_res));
		end
	endtask

	// Results are checked before the item of the same edge is predicted, since a
	// result strobed at that edge always belongs to an earlier item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatches = 0;
			formula_mask = '1;
			drop_clause();
			awaited_results.delete();
		end else begin
			if (strobe)
				check_result(result);
			if (start && !busy)
				evaluate_item(item);
		end
		outstanding = awaited_results.size();
	end

endmodule

// ----- dv/bitsliced_clause_evaluator_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the bit-parallel clause evaluator: makes directed and random items
// and gives the verdict. Depends on bce_pkg, the block and bce_clause_checker.

module bitsliced_clause_evaluator_unit_test;
	import bce_pkg::*;

	localparam int RANDOM_ITEMS = 280;
	localparam int CALM_TAIL    = 40;
	localparam int VARS         = MAX_LITERALS / 2;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    strobe;
	result_t result;
	int      mismatches;
	int      outstanding;

	// Literals written so far; a clause only uses variables with both polarities written.
	bit      lit_written [MAX_LITERALS];
	bit      var_pooled [VARS];
	int      var_pool [$];
	int      sent;
	int      clause_count;
	int      idle_odds;
	bit      calm;

	bitsliced_clause_evaluator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	bce_clause_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.strobe      (strobe),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [WORD_W-1:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	// Truth words of mixed density so that false, true and free lanes all occur.
	function automatic logic [WORD_W-1:0] lane_word();
		case ($urandom_range(0, 9))
			0, 1:    return random_word() & random_word();
			2, 3:    return random_word() | random_word();
			8:       return '0;
			9:       return '1;
			default: return random_word();
		endcase
	endfunction

	// Fields that an opcode ignores get random values.
	function automatic item_t make_item(opcode_t op, int lit, logic [WORD_W-1:0] w, bit last);
		item_t it;
		it.opcode = op;
		it.literal = (op == OP_WRITE || op == OP_CLAUSE) ? LIT_W'(lit)
			: LIT_W'($urandom_range(0, MAX_LITERALS - 1));
		it.word = (op == OP_WRITE) ? w : random_word();
		it.last = (op == OP_CLAUSE) ? last : 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Clause literals come from the most recent variables, so complements and repeats meet.
	function automatic int pick_literal();
		int lo;
		lo = (var_pool.size() > 6) ? var_pool.size() - 6 : 0;
		return 2 * var_pool[$urandom_range(lo, var_pool.size() - 1)] + $urandom_range(0, 1);
	endfunction

	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 99) < idle_odds) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the block takes it.
	task automatic send(item_t it);
		maybe_idle();
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic write_lit(int lit, logic [WORD_W-1:0] w);
		send(make_item(OP_WRITE, lit, w, 1'b0));
		lit_written[lit] = 1'b1;
		if (lit_written[lit ^ 1] && !var_pooled[lit >> 1]) begin
			var_pooled[lit >> 1] = 1'b1;
			var_pool = {var_pool, lit >> 1};
		end
	endtask

	task automatic write_var(int v);
		write_lit(2 * v, lane_word());
		write_lit(2 * v + 1, lane_word());
	endtask

	task automatic query();
		send(make_item(OP_QUERY, 0, '0, 1'b0));
	endtask

	// Stream a clause; an open clause leaves the final mark off. Words of pooled
	// variables are now and then rewritten in the middle of a clause.
	task automatic send_clause(int len, bit closed);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				write_lit(pick_literal(), lane_word());
			send(make_item(OP_CLAUSE, pick_literal(), '0, closed && i == len - 1));
		end
	endtask

	// Pause the item stream until every expected result has been seen.
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// A well-formed formula: fresh variables, a few clauses, then a query.
	task automatic run_formula();
		int odds [3] = '{0, 15, 40};
		idle_odds = odds[$urandom_range(0, 2)];
		send(make_item(OP_START, 0, '0, 1'b0));
		repeat ($urandom_range(1, 3)) write_var($urandom_range(0, VARS - 1));
		repeat ($urandom_range(1, 5)) begin
			clause_count++;
			// Every eighth clause runs past the buffer.
			send_clause((clause_count % 8 == 3) ? $urandom_range(MAX_CLAUSE_LEN + 1, 20)
				: $urandom_range(1, 4), 1'b1);
			if ($urandom_range(0, 9) == 0)
				query();
		end
		query();
	endtask

	// Broken sequences and stray items.
	task automatic run_noise();
		case ($urandom_range(0, 3))
			0: begin
				send_clause($urandom_range(1, 3), 1'b0);
				send(make_item(OP_START, 0, '0, 1'b0));
			end
			1: query();
			2: write_lit($urandom_range(0, MAX_LITERALS - 1), lane_word());
			default: begin
				send_clause($urandom_range(1, 3), 1'b0);
				query();
				send_clause(1, 1'b1);
			end
		endcase
	endtask

	initial begin
		int total;
		idle_odds = 20;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme words and literals, single and repeated literals,
		// query on a fresh formula and with a clause in progress, abandoned clause.
		write_lit(0, '0);
		write_lit(1, '1);
		write_lit(2, 64'h0000_0000_FFFF_FFFF);
		write_lit(3, 64'h0000_FFFF_0000_0000);
		write_lit(MAX_LITERALS - 2, '1);
		write_lit(MAX_LITERALS - 1, '0);
		query();
		send(make_item(OP_CLAUSE, 0, '0, 1'b0));
		send(make_item(OP_CLAUSE, 2, '0, 1'b1));
		send(make_item(OP_CLAUSE, MAX_LITERALS - 1, '0, 1'b1));
		query();
		send(make_item(OP_CLAUSE, 3, '0, 1'b0));
		send(make_item(OP_CLAUSE, 2, '0, 1'b0));
		send(make_item(OP_CLAUSE, 2, '0, 1'b1));
		send(make_item(OP_CLAUSE, 1, '0, 1'b0));
		query();
		send(make_item(OP_START, 0, '0, 1'b0));
		query();
		send(make_item(OP_CLAUSE, MAX_LITERALS - 2, '0, 1'b1));
		query();
		wait_drained();

		// Random formulas with noise mixed in; the tail runs without idling.
		total = sent + RANDOM_ITEMS;
		while (sent < total) begin
			calm = (sent >= total - CALM_TAIL);
			if ($urandom_range(0, 9) < 7)
				run_formula();
			else
				run_noise();
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (24) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
